>>> rtl/core/sfcs_pkg.sv
// Shared types and constants for the SPI flash command sequencer.
package sfcs_pkg;

    localparam logic [7:0] OP_WREN = 8'h06;
    localparam logic [7:0] OP_RDSR = 8'h05;
    localparam logic [0:0] MODE_START = 1'b0;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_WREN_LOW  = 4'd1,
        PH_WREN_BITS = 4'd2,
        PH_WREN_HIGH = 4'd3,
        PH_CMD_LOW   = 4'd4,
        PH_CMD_BITS  = 4'd5,
        PH_DATA      = 4'd6,
        PH_END_HIGH  = 4'd7,
        PH_POLL_LOW  = 4'd8,
        PH_POLL_CMD  = 4'd9,
        PH_POLL_READ = 4'd10,
        PH_POLL_HIGH = 4'd11
    } t_phase;

    typedef struct packed {
        logic f_wait;
        logic f_wren;
        logic f_write;
    } t_flags;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] command_shift;
        logic [5:0]  bits_left;
        logic [15:0] bytes_left;
        logic [15:0] total_length;
        logic [7:0]  data_shift;
        logic [2:0]  bit_in_byte;
        t_flags      flags;
    } t_state;

    typedef struct packed {
        logic        mode;
        logic [31:0] command_word;
        logic [5:0]  command_bits;
        logic [15:0] data_length;
        logic        write_flag;
        logic        wren_first;
        logic        wait_ready;
        logic        so_bit;
        logic [7:0]  write_byte;
    } t_req;

    typedef struct packed {
        logic        ncs;
        logic        si;
        logic        sck_pulse;
        logic        read_valid;
        logic [7:0]  read_byte;
        logic        byte_taken;
        logic        busy_res;
        logic        done_res;
        logic [15:0] result_count;
        logic        rejected;
    } t_res;

endpackage

>>> rtl/core/sfcs_step.sv
// Transaction step logic: next sequencer state and the result for one request.
module sfcs_step import sfcs_pkg::*; (
    input  t_state i_state,
    input  t_req   i_req,
    output t_state o_state,
    output t_res   o_res
);

    logic       active;
    logic       held_ncs;
    logic       done;
    logic [5:0] bits_dec;
    logic [7:0] wr_shift;

    assign active   = (i_state.phase != PH_IDLE);
    assign bits_dec = i_state.bits_left - 6'd1;
    assign wr_shift = (i_state.bit_in_byte == 3'd0) ? i_req.write_byte : i_state.data_shift;

    // Chip-select level held during the frame-internal phases.
    always_comb begin
        unique case (i_state.phase) inside
            PH_WREN_BITS, PH_WREN_HIGH, PH_CMD_BITS, PH_DATA,
            PH_END_HIGH, PH_POLL_CMD, PH_POLL_READ, PH_POLL_HIGH: held_ncs = 1'b0;
            default: held_ncs = 1'b1;
        endcase
    end

    always_comb begin
        o_state = i_state;
        o_res   = '0;
        o_res.ncs = 1'b1;
        done    = 1'b0;

        if (i_req.mode == MODE_START) begin
            if (active) begin
                o_res.rejected = 1'b1;
                o_res.busy_res = 1'b1;
                o_res.ncs      = held_ncs;
            end else begin
                o_state.command_shift = i_req.command_word;
                o_state.bits_left     = i_req.command_bits;
                o_state.total_length  = i_req.data_length;
                o_state.bytes_left    = i_req.data_length;
                o_state.flags.f_write = i_req.write_flag;
                o_state.flags.f_wren  = i_req.wren_first;
                o_state.flags.f_wait  = i_req.wait_ready;
                o_state.data_shift    = '0;
                o_state.bit_in_byte   = '0;
                o_state.phase         = i_req.wren_first ? PH_WREN_LOW : PH_CMD_LOW;
                o_res.busy_res        = 1'b1;
            end
        end else if (active) begin
            o_res.busy_res = 1'b1;
            o_res.ncs      = 1'b0;
            unique case (i_state.phase) inside
                PH_WREN_LOW: begin
                    o_state.data_shift  = OP_WREN;
                    o_state.bit_in_byte = '0;
                    o_state.phase       = PH_WREN_BITS;
                end
                PH_WREN_BITS, PH_POLL_CMD: begin
                    o_res.si           = i_state.data_shift[7];
                    o_res.sck_pulse    = 1'b1;
                    o_state.data_shift = {i_state.data_shift[6:0], 1'b0};
                    if (i_state.bit_in_byte == 3'd7) begin
                        o_state.bit_in_byte = '0;
                        o_state.data_shift  = '0;
                        o_state.phase = (i_state.phase == PH_WREN_BITS) ? PH_WREN_HIGH
                                                                        : PH_POLL_READ;
                    end else begin
                        o_state.bit_in_byte = i_state.bit_in_byte + 3'd1;
                    end
                end
                PH_WREN_HIGH: begin
                    o_res.ncs     = 1'b1;
                    o_state.phase = PH_CMD_LOW;
                end
                PH_CMD_LOW: begin
                    if (i_state.bits_left != '0) begin
                        o_state.phase = PH_CMD_BITS;
                    end else begin
                        o_state.bit_in_byte = '0;
                        o_state.phase = (i_state.bytes_left != '0) ? PH_DATA : PH_END_HIGH;
                    end
                end
                PH_CMD_BITS: begin
                    o_res.si              = i_state.command_shift[31];
                    o_res.sck_pulse       = 1'b1;
                    o_state.command_shift = {i_state.command_shift[30:0], 1'b0};
                    o_state.bits_left     = bits_dec;
                    if (bits_dec == '0) begin
                        o_state.bit_in_byte = '0;
                        o_state.phase = (i_state.bytes_left != '0) ? PH_DATA : PH_END_HIGH;
                    end
                end
                PH_DATA: begin
                    o_res.sck_pulse = 1'b1;
                    if (i_state.flags.f_write) begin
                        o_res.byte_taken   = (i_state.bit_in_byte == 3'd0);
                        o_res.si           = wr_shift[7];
                        o_state.data_shift = {wr_shift[6:0], 1'b0};
                    end else begin
                        o_state.data_shift = {i_state.data_shift[6:0], i_req.so_bit};
                        if (i_state.bit_in_byte == 3'd7) begin
                            o_res.read_valid = 1'b1;
                            o_res.read_byte  = {i_state.data_shift[6:0], i_req.so_bit};
                        end
                    end
                    if (i_state.bit_in_byte == 3'd7) begin
                        o_state.bit_in_byte = '0;
                        o_state.bytes_left  = i_state.bytes_left - 16'd1;
                        if (i_state.bytes_left == 16'd1) begin
                            o_state.phase = PH_END_HIGH;
                        end
                    end else begin
                        o_state.bit_in_byte = i_state.bit_in_byte + 3'd1;
                    end
                end
                PH_END_HIGH: begin
                    o_res.ncs = 1'b1;
                    if (i_state.flags.f_wait) begin
                        o_state.phase = PH_POLL_LOW;
                    end else begin
                        done = 1'b1;
                    end
                end
                PH_POLL_LOW: begin
                    o_state.data_shift  = OP_RDSR;
                    o_state.bit_in_byte = '0;
                    o_state.phase       = PH_POLL_CMD;
                end
                PH_POLL_READ: begin
                    o_res.sck_pulse    = 1'b1;
                    o_state.data_shift = {i_state.data_shift[6:0], i_req.so_bit};
                    if (i_state.bit_in_byte == 3'd7) begin
                        o_state.bit_in_byte = '0;
                        o_state.phase       = PH_POLL_HIGH;
                    end else begin
                        o_state.bit_in_byte = i_state.bit_in_byte + 3'd1;
                    end
                end
                default: begin
                    // Status frame closes; busy bit clear ends the transaction.
                    o_res.ncs = 1'b1;
                    if (!i_state.data_shift[0]) begin
                        done = 1'b1;
                    end else begin
                        o_state.phase = PH_POLL_LOW;
                    end
                end
            endcase
            if (done) begin
                o_res.done_res     = 1'b1;
                o_res.busy_res     = 1'b0;
                o_res.result_count = i_state.flags.f_write ? 16'd0 : i_state.total_length;
                o_state.phase      = PH_IDLE;
            end
        end else begin
            o_state.phase = PH_IDLE;
        end
    end

endmodule

>>> rtl/core/spi_flash_command_sequencer_top.sv
// Top level of the SPI flash command sequencer: request and result registers around the step logic.
//
// Usage. Requests arrive on the input channel (i_in_valid / o_in_stall). A start
// request (i_mode low) loads one flash transaction: an optional write-enable
// frame, a command word of up to 32 bits sent MSB first, a data phase of
// i_data_length bytes written or read, and an optional status poll that repeats
// until the busy bit reads clear. Each tick request (i_mode high) is one bit time
// of the serial link and yields one result on the output channel
// (o_out_valid / i_out_stall) giving chip select, SI, whether a clock pulse is due,
// any completed read byte, and the busy, done and rejected flags.
// Every request produces exactly one result, held first in the request register
// and then in the result register. While i_out_stall is low, a new request
// can be taken every cycle; the rate is one request per cycle, set by the single
// pass of the step logic which updates the sequencer state as a request moves
// from the request register to the result register.
// When the receiver stalls, the result register holds its contents, the held
// request waits, and o_in_stall rises once the request register is also full.
// A synchronous active-low reset empties both registers and returns the
// sequencer to idle, with no transaction in progress.
module spi_flash_command_sequencer_top import sfcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [31:0] i_command_word,
    input  logic [5:0]  i_command_bits,
    input  logic [15:0] i_data_length,
    input  logic        i_write_flag,
    input  logic        i_wren_first,
    input  logic        i_wait_ready,
    input  logic        i_so_bit,
    input  logic [7:0]  i_write_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_ncs,
    output logic        o_si,
    output logic        o_sck_pulse,
    output logic        o_read_valid,
    output logic [7:0]  o_read_byte,
    output logic        o_byte_taken,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [15:0] o_result_count,
    output logic        o_rejected
);

    logic   r_in_valid;
    t_req   r_req;
    logic   r_out_valid;
    t_res   r_res;
    t_state r_state;

    t_state n_state;
    t_res   n_res;
    logic   advance;
    logic   accept;

    // The held request moves on whenever the result register is free or being emptied.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    sfcs_step u_step (
        .i_state (r_state),
        .i_req   (r_req),
        .o_state (n_state),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: PH_IDLE, flags: '0, default: '0};
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.mode         <= i_mode;
            r_req.command_word <= i_command_word;
            r_req.command_bits <= i_command_bits;
            r_req.data_length  <= i_data_length;
            r_req.write_flag   <= i_write_flag;
            r_req.wren_first   <= i_wren_first;
            r_req.wait_ready   <= i_wait_ready;
            r_req.so_bit       <= i_so_bit;
            r_req.write_byte   <= i_write_byte;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_ncs          = r_res.ncs;
    assign o_si           = r_res.si;
    assign o_sck_pulse    = r_res.sck_pulse;
    assign o_read_valid   = r_res.read_valid;
    assign o_read_byte    = r_res.read_byte;
    assign o_byte_taken   = r_res.byte_taken;
    assign o_busy_res     = r_res.busy_res;
    assign o_done_res     = r_res.done_res;
    assign o_result_count = r_res.result_count;
    assign o_rejected     = r_res.rejected;

`ifndef NO_ASSERTIONS
    // A clock pulse is only ever given inside a selected frame.
    a_sck_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sck_pulse |-> !o_ncs)
        else $error("clock pulse with chip select high");

    // The finishing tick reports the transaction as no longer busy.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res && !o_rejected)
        else $error("done result still flagged busy or rejected");

    // A read byte completes, or a write byte is taken, only on a clocked bit.
    a_read_on_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_read_valid || o_byte_taken) |-> o_sck_pulse)
        else $error("data byte event without a clock pulse");

    // Once a transaction is under way, the sequencer state is not idle.
    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_res.busy_res |=> r_state.phase != PH_IDLE)
        else $error("busy result left the sequencer idle");
`endif

endmodule
